// File: rtl/quaternion_product_normaliser_core_macros.svh
// Assertion macros for the quaternion product and normaliser checker.
`ifndef QUATERNION_PRODUCT_NORMALISER_CORE_MACROS_SVH
`define QUATERNION_PRODUCT_NORMALISER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define QPN_ASSERT_NOW(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define QPN_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

// File: rtl/qpn_pkg.sv
// Shared widths, codes, types and helper functions for the quaternion core.
`default_nettype none

package qpn_pkg;

  localparam int COMP_W    = 32;
  localparam int FRAC_W    = 28;
  localparam int NORM_W    = 2 * COMP_W - FRAC_W + 1;
  localparam int LIMIT_W   = 20;
  localparam int PROD_W    = 2 * COMP_W;
  // four products plus sign and headroom
  localparam int ACC_W     = 2 * COMP_W + 2;
  localparam int ROOT_W    = ACC_W / 2;
  localparam int QUO_W     = FRAC_W + 2;
  localparam int RS_W      = COMP_W + 5;
  localparam int STEP_W    = $clog2(ROOT_W);
  localparam int S_TDATA_W = 4 * COMP_W;
  localparam int NORM_LSB  = 4 * COMP_W;
  localparam int M_TDATA_W = ((4 * COMP_W + NORM_W + 7) / 8) * 8;
  localparam int PAD_W     = M_TDATA_W - 4 * COMP_W - NORM_W;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(256);
  localparam logic [COMP_W-1:0]  ONE_VAL   = COMP_W'(64'd1 << FRAC_W);
  localparam logic [COMP_W-1:0]  CMAX      = {1'b0, {(COMP_W - 1){1'b1}}};
  localparam logic [COMP_W-1:0]  CMIN      = {1'b1, {(COMP_W - 1){1'b0}}};
  localparam logic [ACC_W-1:0]   RND_HALF  = ACC_W'(1) << (FRAC_W - 1);

  // Hamilton product term signs, indexed {component, term}: set = subtract
  localparam logic [15:0] HP_NEG = 16'h428E;

  typedef logic signed [COMP_W-1:0] comp_t;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_MUL   = 2'd1,
    OP_NORM  = 2'd2,
    OP_IDENT = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_ISS,
    ST_MUL_WAIT,
    ST_MUL_COMMIT,
    ST_SQ_ISS,
    ST_SQ_WAIT,
    ST_CHECK,
    ST_SQRT_WAIT,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_DIV_COMMIT,
    ST_FIN
  } st_e;

  // Multiply-accumulate issue control
  typedef struct packed {
    logic vld;
    logic neg;
    logic first;
    logic last;
  } mac_ctl_t;

  // Root / divide unit start control
  typedef struct packed {
    logic start_sqrt;
    logic start_div;
  } rd_ctl_t;

  // Round half up to FRAC_W fraction bits, then saturate to a component
  function automatic comp_t round_sat(input logic signed [ACC_W-1:0] s);
    logic signed [ACC_W-1:0]          t;
    logic [ACC_W-FRAC_W-1:0]          sh;
    logic [ACC_W-FRAC_W-COMP_W:0]     top;
    comp_t                            res;
    t   = s + RND_HALF;
    sh  = t[ACC_W-1:FRAC_W];
    top = sh[ACC_W-FRAC_W-1:COMP_W-1];
    if (top == '0 || top == '1) begin
      res = sh[COMP_W-1:0];
    end else if (sh[ACC_W-FRAC_W-1]) begin
      res = CMIN;
    end else begin
      res = CMAX;
    end
    return res;
  endfunction

  // Squared magnitude in output format, saturating at all ones
  function automatic logic [NORM_W-1:0] norm_of(input logic [ACC_W-1:0] s);
    logic [ACC_W-FRAC_W-1:0] t;
    logic [NORM_W-1:0]       res;
    t = s[ACC_W-1:FRAC_W];
    if (|t[ACC_W-FRAC_W-1:NORM_W]) begin
      res = '1;
    end else begin
      res = t[NORM_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: rtl/qpn_mac.sv
// Shared signed multiplier with registered product and add/subtract accumulator.
`default_nettype none

module qpn_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  qpn_pkg::mac_ctl_t                   ctl_i,
  input  qpn_pkg::comp_t                      a_i,
  input  qpn_pkg::comp_t                      b_i,
  output logic signed [qpn_pkg::ACC_W-1:0]    acc_o,
  output logic                                done_o
);
  import qpn_pkg::*;

  mac_ctl_t                 pctl_q;
  logic                     done_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_d;
  logic signed [ACC_W-1:0]  prod_ext;

  // Track the issued term through the product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pctl_q <= '0;
      done_q <= 1'b0;
    end else begin
      pctl_q <= ctl_i;
      done_q <= pctl_q.vld & pctl_q.last;
    end
  end

  // Add or subtract the product, restarting on the first term of a group
  always_comb begin
    prod_ext = {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
    if (pctl_q.neg) begin
      acc_d = (pctl_q.first ? '0 : acc_q) - prod_ext;
    end else begin
      acc_d = (pctl_q.first ? '0 : acc_q) + prod_ext;
    end
  end

  // Product and accumulator registers
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    if (pctl_q.vld) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

// File: rtl/qpn_rootdiv.sv
// Iterative square root and restoring divider sharing one subtractor.
`default_nettype none

module qpn_rootdiv (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  qpn_pkg::rd_ctl_t              ctl_i,
  input  logic [qpn_pkg::ACC_W-1:0]     rad_i,
  input  logic [qpn_pkg::COMP_W-1:0]    num_i,
  output logic                          done_o,
  output logic [qpn_pkg::QUO_W-1:0]     quo_o
);
  import qpn_pkg::*;

  logic              busy_q;
  logic              sqrt_q;
  logic              done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [RS_W-1:0]   rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [ACC_W-1:0]  src_q;
  logic [QUO_W-1:0]  quo_q;

  logic [RS_W-1:0]   opa;
  logic [RS_W-1:0]   opb;
  logic [RS_W:0]     diff;
  logic              ge;
  logic [RS_W-1:0]   rem_nx;

  // Shared trial subtraction: two radicand bits per root step, one per divide step
  always_comb begin
    if (sqrt_q) begin
      opa = {rem_q[RS_W-3:0], src_q[ACC_W-1 -: 2]};
      opb = RS_W'({root_q, 2'b01});
    end else begin
      opa = {rem_q[RS_W-2:0], src_q[ACC_W-1]};
      opb = RS_W'(root_q);
    end
    diff   = {1'b0, opa} - {1'b0, opb};
    ge     = ~diff[RS_W];
    rem_nx = ge ? diff[RS_W-1:0] : opa;
  end

  // Step counter and completion pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sqrt_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (ctl_i.start_sqrt) begin
        busy_q <= 1'b1;
        sqrt_q <= 1'b1;
        cnt_q  <= STEP_W'(ROOT_W - 1);
      end else if (ctl_i.start_div) begin
        busy_q <= 1'b1;
        sqrt_q <= 1'b0;
        cnt_q  <= STEP_W'(QUO_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q - STEP_W'(1);
      end
    end
  end

  // Remainder, root, quotient and operand shift register; root is kept for the divides
  always_ff @(posedge clk_i) begin
    if (ctl_i.start_sqrt) begin
      rem_q  <= '0;
      root_q <= '0;
      src_q  <= rad_i;
    end else if (ctl_i.start_div) begin
      // quotient stays below 2^QUO_W, so the top numerator bits seed the remainder
      rem_q <= RS_W'(num_i >> 1);
      src_q <= {num_i[0], {(ACC_W - 1){1'b0}}};
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_nx;
      if (sqrt_q) begin
        root_q <= {root_q[ROOT_W-2:0], ge};
        src_q  <= src_q << 2;
      end else begin
        quo_q <= {quo_q[QUO_W-2:0], ge};
        src_q <= src_q << 1;
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// File: rtl/quaternion_product_normaliser_core.sv
// Quaternion accumulator: Hamilton product and normalise in Q4.28, squared magnitude in Q9.28.
// Multiply runs 16 products through the one multiplier; normalise takes 33 root steps, then one
// divide per component on the shared subtractor, unless the norm is too small.
// One item at a time: the next transfer is taken the cycle after the result is registered,
// later while a stalled result still holds the output.
`default_nettype none

module quaternion_product_normaliser_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [qpn_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // in_w, in_x, in_y, in_z
  input  logic [1:0]                        s_axis_tuser,  // op
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [qpn_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // out_w, out_x, out_y, out_z, norm_sq
  output logic [0:0]                        m_axis_tuser,  // zero_error
  input  logic                              cfg_we_i,
  input  logic [qpn_pkg::LIMIT_W-1:0]       cfg_wdata_i
);
  import qpn_pkg::*;

  st_e                     state_q, state_d;
  logic [3:0]              cnt_q, cnt_d;
  logic [1:0]              wr_idx_q, wr_idx_d;
  logic [1:0]              cmp_q, cmp_d;
  logic                    npend_q, npend_d;
  logic                    err_q, err_d;
  logic [LIMIT_W-1:0]      zlim_q;
  logic                    m_valid_q;
  logic [M_TDATA_W-1:0]    mdata_q;
  logic                    merr_q;
  comp_t                   held_q [4];
  comp_t                   nh_q   [4];
  comp_t                   opd_q  [4];
  comp_t                   in_c   [4];

  logic                    accept;
  logic                    held_load;
  logic                    held_ident;
  logic                    held_commit;
  logic                    nh_we;
  logic [1:0]              nh_idx;
  comp_t                   nh_val;
  logic                    out_ld;

  mac_ctl_t                mac_ctl;
  comp_t                   mac_a;
  comp_t                   mac_b;
  logic signed [ACC_W-1:0] acc;
  logic                    mac_done;
  logic [NORM_W-1:0]       norm_cur;

  rd_ctl_t                 rd_ctl;
  logic                    rd_done;
  logic [QUO_W-1:0]        quo;
  logic [COMP_W-1:0]       div_num;
  logic [QUO_W:0]          quo_inc;
  comp_t                   div_pos;
  comp_t                   div_res;

  // Unpack the operand components
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      in_c[k] = s_axis_tdata[k*COMP_W +: COMP_W];
    end
  end

  assign accept   = s_axis_tvalid & s_axis_tready;
  assign norm_cur = norm_of(acc);

  // Divider operand magnitude and rounded, signed quotient
  always_comb begin
    div_num = held_q[cmp_q][COMP_W-1] ? COMP_W'(-held_q[cmp_q]) : held_q[cmp_q];
    quo_inc = {1'b0, quo} + (QUO_W + 1)'(1);
    div_pos = COMP_W'(quo_inc[QUO_W:1]);
    div_res = held_q[cmp_q][COMP_W-1] ? -div_pos : div_pos;
  end

  qpn_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (acc),
    .done_o (mac_done)
  );

  qpn_rootdiv u_rootdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (rd_ctl),
    .rad_i  (acc),
    .num_i  (div_num),
    .done_o (rd_done),
    .quo_o  (quo)
  );

  // Sequencer: next state, issue control and update strobes
  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    wr_idx_d      = wr_idx_q;
    cmp_d         = cmp_q;
    npend_d       = npend_q;
    err_d         = err_q;
    held_load     = 1'b0;
    held_ident    = 1'b0;
    held_commit   = 1'b0;
    nh_we         = 1'b0;
    nh_idx        = wr_idx_q;
    nh_val        = round_sat(acc);
    out_ld        = 1'b0;
    mac_ctl       = '0;
    mac_a         = held_q[cnt_q[1:0]];
    mac_b         = held_q[cnt_q[1:0]];
    rd_ctl        = '0;
    s_axis_tready = 1'b0;

    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          err_d    = 1'b0;
          wr_idx_d = '0;
          cnt_d    = '0;
          cmp_d    = '0;
          npend_d  = 1'b0;
          case (op_e'(s_axis_tuser))
            OP_LOAD: begin
              held_load = 1'b1;
              state_d   = ST_SQ_ISS;
            end
            OP_IDENT: begin
              held_ident = 1'b1;
              state_d    = ST_SQ_ISS;
            end
            OP_MUL: begin
              state_d = ST_MUL_ISS;
            end
            OP_NORM: begin
              npend_d = 1'b1;
              state_d = ST_SQ_ISS;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      // Issue one Hamilton term a cycle; round each finished component
      ST_MUL_ISS: begin
        mac_b         = opd_q[cnt_q[3:2] ^ cnt_q[1:0]];
        mac_ctl.vld   = 1'b1;
        mac_ctl.neg   = HP_NEG[cnt_q];
        mac_ctl.first = (cnt_q[1:0] == 2'd0);
        mac_ctl.last  = (cnt_q[1:0] == 2'd3);
        cnt_d         = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          state_d = ST_MUL_WAIT;
        end
        if (mac_done) begin
          nh_we    = 1'b1;
          wr_idx_d = wr_idx_q + 2'd1;
        end
      end

      ST_MUL_WAIT: begin
        if (mac_done) begin
          nh_we    = 1'b1;
          wr_idx_d = wr_idx_q + 2'd1;
          if (wr_idx_q == 2'd3) begin
            state_d = ST_MUL_COMMIT;
          end
        end
      end

      ST_MUL_COMMIT: begin
        held_commit = 1'b1;
        cnt_d       = '0;
        state_d     = ST_SQ_ISS;
      end

      // Sum of squares of the held components
      ST_SQ_ISS: begin
        mac_ctl.vld   = 1'b1;
        mac_ctl.first = (cnt_q[1:0] == 2'd0);
        mac_ctl.last  = (cnt_q[1:0] == 2'd3);
        cnt_d         = cnt_q + 4'd1;
        if (cnt_q[1:0] == 2'd3) begin
          cnt_d   = '0;
          state_d = ST_SQ_WAIT;
        end
      end

      ST_SQ_WAIT: begin
        if (mac_done) begin
          state_d = npend_q ? ST_CHECK : ST_FIN;
        end
      end

      // Refuse to normalise a near-zero quaternion
      ST_CHECK: begin
        npend_d = 1'b0;
        if (norm_cur <= NORM_W'(zlim_q)) begin
          err_d   = 1'b1;
          state_d = ST_FIN;
        end else begin
          rd_ctl.start_sqrt = 1'b1;
          state_d           = ST_SQRT_WAIT;
        end
      end

      ST_SQRT_WAIT: begin
        if (rd_done) begin
          state_d = ST_DIV_START;
        end
      end

      ST_DIV_START: begin
        rd_ctl.start_div = 1'b1;
        state_d          = ST_DIV_WAIT;
      end

      ST_DIV_WAIT: begin
        if (rd_done) begin
          nh_we   = 1'b1;
          nh_idx  = cmp_q;
          nh_val  = div_res;
          cmp_d   = cmp_q + 2'd1;
          state_d = (cmp_q == 2'd3) ? ST_DIV_COMMIT : ST_DIV_START;
        end
      end

      ST_DIV_COMMIT: begin
        held_commit = 1'b1;
        cnt_d       = '0;
        state_d     = ST_SQ_ISS;
      end

      // Hand the result to the output register once it is free
      ST_FIN: begin
        if (!m_valid_q || m_axis_tready) begin
          out_ld  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state, held quaternion and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      wr_idx_q  <= '0;
      cmp_q     <= '0;
      npend_q   <= 1'b0;
      err_q     <= 1'b0;
      zlim_q    <= LIMIT_RST;
      m_valid_q <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        held_q[k] <= '0;
      end
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      wr_idx_q  <= wr_idx_d;
      cmp_q     <= cmp_d;
      npend_q   <= npend_d;
      err_q     <= err_d;
      m_valid_q <= out_ld | (m_valid_q & ~m_axis_tready);
      if (cfg_we_i) begin
        zlim_q <= cfg_wdata_i;
      end
      if (held_load) begin
        for (int k = 0; k < 4; k++) begin
          held_q[k] <= in_c[k];
        end
      end else if (held_ident) begin
        held_q[0] <= ONE_VAL;
        held_q[1] <= '0;
        held_q[2] <= '0;
        held_q[3] <= '0;
      end else if (held_commit) begin
        for (int k = 0; k < 4; k++) begin
          held_q[k] <= nh_q[k];
        end
      end
    end
  end

  // Operand, new-value and output payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int k = 0; k < 4; k++) begin
        opd_q[k] <= in_c[k];
      end
    end
    if (nh_we) begin
      nh_q[nh_idx] <= nh_val;
    end
    if (out_ld) begin
      mdata_q <= {{PAD_W{1'b0}}, norm_cur, held_q[3], held_q[2], held_q[1], held_q[0]};
      merr_q  <= err_q;
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = mdata_q;
  assign m_axis_tuser[0] = merr_q;

endmodule

`default_nettype wire

// File: rtl/qpn_checker.sv
// Port-level checker for the quaternion core, bound to the top level.
`default_nettype none

`include "quaternion_product_normaliser_core_macros.svh"

module qpn_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [qpn_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input logic [0:0]                     m_axis_tuser
);
  import qpn_pkg::*;

  // Stalled result holds
  `QPN_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // No input is taken in the cycle right after a transfer
  `QPN_ASSERT_NEXT(a_busy_after_in, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken back to back")

  // A new result only follows work in progress
  `QPN_ASSERT_NOW(a_result_from_work, $rose(m_axis_tvalid), !$past(s_axis_tready), "result appeared while idle")

  // A zero quaternion has zero squared magnitude
  `QPN_ASSERT_NOW(a_zero_norm, m_axis_tvalid && (m_axis_tdata[NORM_LSB-1:0] == '0), m_axis_tdata[NORM_LSB+NORM_W-1:NORM_LSB] == '0, "nonzero norm for zero quaternion")

  // A zero error only arises with a norm within the limit range
  `QPN_ASSERT_NOW(a_err_small_norm, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[NORM_LSB+NORM_W-1:NORM_LSB+LIMIT_W] == '0, "zero error with large norm")

endmodule

bind quaternion_product_normaliser_core qpn_checker u_qpn_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// File: dv/qpn_result_checker.sv
// Result checker for the quaternion core: watches both streams, predicts and compares.
`timescale 1ns / 1ps

module qpn_result_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  input  logic [qpn_pkg::S_TDATA_W-1:0] s_tdata_i,     // in_w, in_x, in_y, in_z
  input  logic [1:0]                    s_tuser_i,     // op
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  input  logic [qpn_pkg::M_TDATA_W-1:0] m_tdata_i,     // out_w, out_x, out_y, out_z, norm_sq
  input  logic [0:0]                    m_tuser_i,     // zero_error
  input  logic                          cfg_we_i,
  input  logic [qpn_pkg::LIMIT_W-1:0]   cfg_wdata_i,
  output int                            fail_count_o,
  output int                            outstanding_o
);
  import qpn_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    comp_t             w;
    comp_t             x;
    comp_t             y;
    comp_t             z;
    logic [NORM_W-1:0] nsq;
    logic              zerr;
  } quat_result_t;

  localparam wide_t COMP_TOP    = (128'sd1 <<< (COMP_W - 1)) - 128'sd1;
  localparam wide_t COMP_BOTTOM = -(128'sd1 <<< (COMP_W - 1));

  // Predicted copy of the held quaternion and the limit register
  comp_t              held_w, held_x, held_y, held_z;
  logic [LIMIT_W-1:0] limit_q;
  quat_result_t       predicted_q[$];
  int                 fails = 0;
  int                 pending_n = 0;

  assign fail_count_o  = fails;
  assign outstanding_o = pending_n;

  // Clamp a wide signed value to the component range
  function automatic comp_t clamp_comp(input wide_t v);
    if (v > COMP_TOP) return comp_t'(COMP_TOP[COMP_W-1:0]);
    if (v < COMP_BOTTOM) return comp_t'(COMP_BOTTOM[COMP_W-1:0]);
    return v[COMP_W-1:0];
  endfunction

  // Round half up from 2*FRAC_W to FRAC_W fraction bits, then clamp
  function automatic comp_t round_clamp(input wide_t v);
    wide_t t;
    t = (v + (128'sd1 <<< (FRAC_W - 1))) >>> FRAC_W;
    return clamp_comp(t);
  endfunction

  function automatic logic [127:0] square_sum(input comp_t w, x, y, z);
    wide_t a, b, c, d;
    a = w;
    b = x;
    c = y;
    d = z;
    return a * a + b * b + c * c + d * d;
  endfunction

  // Squared magnitude in output format, pinned at all ones on overflow
  function automatic logic [NORM_W-1:0] norm_field(input logic [127:0] s);
    logic [127:0] t;
    t = s >> FRAC_W;
    if ((t >> NORM_W) != 0) return '1;
    return t[NORM_W-1:0];
  endfunction

  function automatic logic [63:0] floor_root(input logic [127:0] s);
    logic [63:0]  r;
    logic [63:0]  c;
    logic [127:0] c2;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c  = r | (64'd1 << b);
      c2 = {64'd0, c} * {64'd0, c};
      if (c2 <= s) r = c;
    end
    return r;
  endfunction

  // Divide one component by the root, rounding the magnitude half up
  function automatic comp_t unit_scale(input comp_t c, input logic [63:0] r);
    wide_t        cs;
    logic [127:0] mag;
    logic [127:0] q;
    cs  = c;
    mag = (cs < 0) ? -cs : cs;
    q   = (mag << (FRAC_W + 1)) / {64'd0, r};
    q   = (q + 128'd1) >> 1;
    if (cs < 0) q = -q;
    return clamp_comp($signed(q));
  endfunction

  // Advance the held quaternion by one operation and form its result
  task automatic apply_item(input op_e op, input comp_t bw, bx, by, bz,
                            output quat_result_t res);
    wide_t        aw, ax, ay, az, cw, cx, cy, cz;
    comp_t        nw, nx, ny, nz;
    logic [127:0] ssq;
    logic [63:0]  root;
    logic         err;
    aw  = held_w;
    ax  = held_x;
    ay  = held_y;
    az  = held_z;
    cw  = bw;
    cx  = bx;
    cy  = by;
    cz  = bz;
    err = 1'b0;
    case (op)
      OP_LOAD: begin
        held_w = bw;
        held_x = bx;
        held_y = by;
        held_z = bz;
      end
      OP_MUL: begin
        nw = round_clamp(aw * cw - ax * cx - ay * cy - az * cz);
        nx = round_clamp(aw * cx + ax * cw + ay * cz - az * cy);
        ny = round_clamp(aw * cy - ax * cz + ay * cw + az * cx);
        nz = round_clamp(aw * cz + ax * cy - ay * cx + az * cw);
        held_w = nw;
        held_x = nx;
        held_y = ny;
        held_z = nz;
      end
      OP_NORM: begin
        ssq = square_sum(held_w, held_x, held_y, held_z);
        // near zero: keep the quaternion and flag it
        if (norm_field(ssq) <= {{(NORM_W - LIMIT_W){1'b0}}, limit_q}) begin
          err = 1'b1;
        end else begin
          root   = floor_root(ssq);
          held_w = unit_scale(held_w, root);
          held_x = unit_scale(held_x, root);
          held_y = unit_scale(held_y, root);
          held_z = unit_scale(held_z, root);
        end
      end
      default: begin
        held_w = clamp_comp(128'sd1 <<< FRAC_W);
        held_x = '0;
        held_y = '0;
        held_z = '0;
      end
    endcase
    ssq      = square_sum(held_w, held_x, held_y, held_z);
    res.w    = held_w;
    res.x    = held_x;
    res.y    = held_y;
    res.z    = held_z;
    res.nsq  = norm_field(ssq);
    res.zerr = err;
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endtask

  // Compare output transfers, track config writes, predict input transfers
  always @(posedge clk_i or negedge rst_ni) begin
    quat_result_t want;
    quat_result_t next_res;
    if (!rst_ni) begin
      held_w  = '0;
      held_x  = '0;
      held_y  = '0;
      held_z  = '0;
      limit_q = LIMIT_RST;
      predicted_q.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (predicted_q.size() == 0) begin
          $error("result transfer with no prediction waiting");
          fails++;
        end else begin
          want = predicted_q.pop_front();
          check_field("out_w", longint'(want.w), longint'($signed(m_tdata_i[0 +: COMP_W])));
          check_field("out_x", longint'(want.x),
                      longint'($signed(m_tdata_i[COMP_W +: COMP_W])));
          check_field("out_y", longint'(want.y),
                      longint'($signed(m_tdata_i[2 * COMP_W +: COMP_W])));
          check_field("out_z", longint'(want.z),
                      longint'($signed(m_tdata_i[3 * COMP_W +: COMP_W])));
          check_field("norm_sq", longint'(want.nsq),
                      longint'(m_tdata_i[NORM_LSB +: NORM_W]));
          check_field("zero_error", longint'(want.zerr), longint'(m_tuser_i[0]));
        end
      end
      if (cfg_we_i) limit_q = cfg_wdata_i;
      if (s_tvalid_i && s_tready_i) begin
        apply_item(op_e'(s_tuser_i), s_tdata_i[0 +: COMP_W], s_tdata_i[COMP_W +: COMP_W],
                   s_tdata_i[2 * COMP_W +: COMP_W], s_tdata_i[3 * COMP_W +: COMP_W],
                   next_res);
        predicted_q.push_back(next_res);
      end
    end
    pending_n = predicted_q.size();
  end

endmodule

// File: dv/tb_quaternion_product_normaliser_core.sv
// Testbench top for the quaternion core: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_quaternion_product_normaliser_core;
  import qpn_pkg::*;

  localparam int CYCLE_LIMIT     = 3_000_000;
  localparam int PHASES          = 5;
  localparam int ITEMS_PER_PHASE = 280;
  localparam int DRAIN_CYCLES    = 200;
  localparam int LONG_HOLD       = 500;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;   // in_w, in_x, in_y, in_z
  logic [1:0]           s_axis_tuser;   // op
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;   // out_w, out_x, out_y, out_z, norm_sq
  logic [0:0]           m_axis_tuser;   // zero_error
  logic                 cfg_we_i;
  logic [LIMIT_W-1:0]   cfg_wdata_i;

  int fail_count;
  int outstanding;
  int cycle_count = 0;
  int hold_len    = 0;
  bit steady      = 1'b0;

  quaternion_product_normaliser_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  qpn_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .s_tuser_i     (s_axis_tuser),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .m_tuser_i     (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one; none while steady
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Operand component: full range, near unit, small magnitude or extreme
  function automatic comp_t rand_comp(input int kind);
    int    mag;
    comp_t c;
    case (kind)
      0: c = $urandom();
      1: c = int'($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
      2: begin
        mag = $urandom_range(0, 1 << $urandom_range(8, 24));
        c   = $urandom_range(0, 1) ? -mag : mag;
      end
      default: begin
        case ($urandom_range(0, 4))
          0: c = CMAX;
          1: c = CMIN;
          2: c = '0;
          3: c = -1;
          default: c = 1;
        endcase
      end
    endcase
    return c;
  endfunction

  // Offer one item and hold it until the transfer; leaves tvalid high
  task automatic send_item(input op_e op, input comp_t w, x, y, z);
    int gap;
    gap = idle_len();
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  = {z, y, x, w};
    s_axis_tuser  = op;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Stop offering and wait for every predicted result to arrive
  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  task automatic set_limit(input logic [LIMIT_W-1:0] v);
    drain_results();
    cfg_wdata_i = v;
    cfg_we_i    = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_len != 0) begin
        m_axis_tready = 1'b0;
        repeat (hold_len) @(negedge clk_i);
        hold_len = 0;
      end else begin
        gap = idle_len();
        if (gap != 0) begin
          m_axis_tready = 1'b0;
          repeat (gap) @(negedge clk_i);
        end
        m_axis_tready = 1'b1;
        @(negedge clk_i);
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_quaternion_product_normaliser_core: done, errors");
    $finish;
  end

  initial begin
    op_e op;
    int  r;
    int  kind;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Limit at reset value: zero held, identity, limit boundary, extremes
    send_item(OP_NORM, 1, -1, CMAX, CMIN);
    send_item(OP_IDENT, -1, -1, -1, -1);
    send_item(OP_NORM, 0, 0, 0, 0);
    send_item(OP_LOAD, 1 << 18, 0, 0, 0);
    send_item(OP_NORM, 0, 0, 0, 0);
    send_item(OP_LOAD, (1 << 18) + (1 << 10), 0, 0, 0);
    send_item(OP_NORM, 0, 0, 0, 0);
    send_item(OP_LOAD, CMAX, CMIN, CMAX, CMIN);
    send_item(OP_NORM, 0, 0, 0, 0);
    send_item(OP_LOAD, CMIN, CMIN, CMIN, CMIN);
    send_item(OP_MUL, CMIN, CMIN, CMIN, CMIN);
    send_item(OP_LOAD, CMAX, CMAX, CMAX, CMAX);
    send_item(OP_MUL, CMAX, CMIN, CMAX, CMIN);
    send_item(OP_LOAD, -1, -1, -1, -1);
    send_item(OP_MUL, -1, 1, -1, 1);
    send_item(OP_IDENT, CMAX, CMAX, CMAX, CMAX);
    send_item(OP_MUL, 0, ONE_VAL, 0, 0);

    // Limit at zero: only an all-zero norm fails
    set_limit('0);
    send_item(OP_LOAD, 0, 0, 0, 0);
    send_item(OP_NORM, 0, 0, 0, 0);
    send_item(OP_LOAD, 0, 0, 0, 1 << 14);
    send_item(OP_NORM, 0, 0, 0, 0);

    // Limit at all ones: just above and just below
    set_limit('1);
    send_item(OP_LOAD, 1 << 24, 0, 0, 0);
    send_item(OP_NORM, 0, 0, 0, 0);
    send_item(OP_LOAD, 0, -((1 << 24) - 1), 0, 0);
    send_item(OP_NORM, 0, 0, 0, 0);

    // Random phases, each under its own limit
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1: begin
          set_limit($urandom_range(0, 4096));
          steady = 1'b1;
        end
        2: begin
          set_limit(LIMIT_RST);
          steady   = 1'b0;
          hold_len = LONG_HOLD;
        end
        default: set_limit($urandom_range(0, (1 << LIMIT_W) - 1));
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        r  = $urandom_range(0, 99);
        op = (r < 25) ? OP_LOAD : (r < 60) ? OP_MUL : (r < 85) ? OP_NORM : OP_IDENT;
        r  = $urandom_range(0, 99);
        kind = (r < 20) ? 0 : (r < 65) ? 1 : (r < 90) ? 2 : 3;
        send_item(op, rand_comp(kind), rand_comp(kind), rand_comp(kind), rand_comp(kind));
        // occasionally pause until the block has emptied
        if ($urandom_range(0, 99) < 2) drain_results();
      end
    end
    steady = 1'b0;

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb_quaternion_product_normaliser_core: done, clean");
    end else begin
      $display("tb_quaternion_product_normaliser_core: done, errors");
    end
    $finish;
  end

endmodule
